// ----- src/nrmc_pkg.sv -----
// Shared types, character codes and lookup functions for the NMEA RMC
// time-to-segment block. No dependencies.
package nrmc_pkg;

	// Parser steps: wait for '$', match "GPRMC", match ',', then the fields.
	typedef enum logic [3:0] {
		ST_DOLLAR  = 4'd0,
		ST_G       = 4'd1,
		ST_P       = 4'd2,
		ST_R       = 4'd3,
		ST_M       = 4'd4,
		ST_C       = 4'd5,
		ST_COMMA   = 4'd6,
		ST_TIME    = 4'd7,
		ST_VALID   = 4'd8,
		ST_STAR    = 4'd9,
		ST_SUM_HI  = 4'd10,
		ST_SUM_LO  = 4'd11
	} nrmc_step_t;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] HEX_ADJUST  = 8'h37;

	localparam logic [7:0] COLON_BIT   = 8'h80;
	localparam logic [3:0] ZONE_RESET  = 4'd4;
	localparam logic [4:0] FIELD_MAX   = 5'd16;
	localparam logic [4:0] FOLD_MIN    = 5'd7;
	localparam int unsigned NUM_DIGITS = 4;

	// Time nibbles and status handed from the parser to the segment stage.
	typedef struct packed {
		logic       hit;
		logic       fix_valid;
		logic [3:0] hour_tens;
		logic [3:0] hour_ones;
		logic [3:0] minute_tens;
		logic [3:0] minute_ones;
	} nrmc_time_t;

	// Expected header character for header steps G through C.
	function automatic logic [7:0] header_char(input nrmc_step_t step);
		logic [7:0] ch;
		case (step)
			ST_G:    ch = 8'h47;
			ST_P:    ch = 8'h50;
			ST_R:    ch = 8'h52;
			ST_M:    ch = 8'h4D;
			ST_C:    ch = 8'h43;
			default: ch = CHAR_DOLLAR;
		endcase
		return ch;
	endfunction

	// Uppercase hex digit to nibble; other characters give their wrapped value.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] adj;
		adj = (c > CHAR_NINE) ? (c - HEX_ADJUST) : c;
		return adj[3:0];
	endfunction

	// Seven-segment pattern, bit0 = a .. bit6 = g; codes above nine are blank.
	function automatic logic [7:0] seg_digit(input logic [3:0] d);
		logic [7:0] p;
		case (d)
			4'd0:    p = 8'h3F;
			4'd1:    p = 8'h06;
			4'd2:    p = 8'h5B;
			4'd3:    p = 8'h4F;
			4'd4:    p = 8'h66;
			4'd5:    p = 8'h6D;
			4'd6:    p = 8'h7D;
			4'd7:    p = 8'h07;
			4'd8:    p = 8'h7F;
			4'd9:    p = 8'h6F;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

// ----- src/nrmc_rx_if.sv -----
// Handshake channel carrying one received byte per item.
// No dependencies.
interface nrmc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/nrmc_seg_if.sv -----
// Handshake channel carrying four seven-segment bytes per item.
// No dependencies.
interface nrmc_seg_if;
	logic       valid;
	logic       ready;
	logic [7:0] seg_hour_tens;
	logic [7:0] seg_hour_ones;
	logic [7:0] seg_minute_tens;
	logic [7:0] seg_minute_ones;

	modport source (output valid, output seg_hour_tens, output seg_hour_ones,
		output seg_minute_tens, output seg_minute_ones, input ready);
	modport sink (input valid, input seg_hour_tens, input seg_hour_ones,
		input seg_minute_tens, input seg_minute_ones, output ready);
endinterface

// ----- src/nrmc_cfg_if.sv -----
// Configuration write channel for the zone offset register.
// No dependencies.
interface nrmc_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] zone_offset_hours;

	modport source (output valid, output zone_offset_hours, input ready);
	modport sink (input valid, input zone_offset_hours, output ready);
endinterface

// ----- src/nrmc_hour_fold.sv -----
// Folds a 24-hour UTC hour to 12-hour form and subtracts the zone offset.
// Depends on nrmc_pkg.
module nrmc_hour_fold
	import nrmc_pkg::*;
(
	input  logic [3:0] tens,
	input  logic [3:0] ones,
	input  logic [3:0] zone,
	output logic [3:0] tens_out,
	output logic [3:0] ones_out
);

	logic [7:0] hour_raw;
	logic [7:0] hour_12;
	logic [7:0] hour_up;
	logic [9:0] diff;
	logic       wide;

	always_comb begin
		hour_raw = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
		hour_12  = (hour_raw > 8'd12) ? (hour_raw - 8'd12) : hour_raw;
		hour_up  = (hour_12 <= {4'b0000, zone}) ? (hour_12 + 8'd12) : hour_12;
		diff     = {2'b00, hour_up} - {6'b000000, zone};
		// A negative difference wraps to a huge value, so it counts as above nine.
		wide     = diff[9] || (diff[8:0] > 9'd9);
		tens_out = wide ? 4'd1 : 4'd0;
		ones_out = wide ? (diff[3:0] - 4'd10) : diff[3:0];
	end

endmodule

// ----- src/nrmc_parser.sv -----
// Sentence parser: header match, time capture, validity, checksum.
// Depends on nrmc_pkg and nrmc_hour_fold.
module nrmc_parser
	import nrmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] rx_byte,
	input  logic [3:0] zone,
	output nrmc_time_t result
);

	nrmc_step_t step_q, step_n;
	logic [4:0] count_q, count_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] capt_q, capt_n;
	logic [3:0] sum_hi_q, sum_hi_n;
	logic       fix_q, fix_n;
	logic [3:0] nib_q [NUM_DIGITS];
	logic [3:0] nib_n [NUM_DIGITS];
	logic [3:0] fold_tens, fold_ones;
	logic       hit;

	nrmc_hour_fold u_fold (
		.tens     (nib_q[0]),
		.ones     (nib_q[1]),
		.zone     (zone),
		.tens_out (fold_tens),
		.ones_out (fold_ones)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_DOLLAR;
			count_q  <= '0;
			xor_q    <= '0;
			capt_q   <= '0;
			sum_hi_q <= '0;
			fix_q    <= 1'b0;
			for (int i = 0; i < NUM_DIGITS; i++) nib_q[i] <= '0;
		end else if (step_en) begin
			step_q   <= step_n;
			count_q  <= count_n;
			xor_q    <= xor_n;
			capt_q   <= capt_n;
			sum_hi_q <= sum_hi_n;
			fix_q    <= fix_n;
			for (int i = 0; i < NUM_DIGITS; i++) nib_q[i] <= nib_n[i];
		end
	end

	always_comb begin
		step_n   = step_q;
		count_n  = count_q;
		capt_n   = capt_q;
		sum_hi_n = sum_hi_q;
		fix_n    = fix_q;
		hit      = 1'b0;
		for (int i = 0; i < NUM_DIGITS; i++) nib_n[i] = nib_q[i];
		// The star never enters the checksum.
		xor_n = (rx_byte != CHAR_STAR) ? (xor_q ^ rx_byte) : xor_q;

		case (step_q)
			ST_G, ST_P, ST_R, ST_M, ST_C: begin
				step_n = (rx_byte == header_char(step_q)) ?
					nrmc_step_t'(step_q + 4'd1) : ST_DOLLAR;
			end
			ST_COMMA: begin
				count_n = '0;
				step_n  = (rx_byte == CHAR_COMMA) ? ST_TIME : ST_DOLLAR;
			end
			ST_TIME: begin
				if (rx_byte == CHAR_COMMA) begin
					if (count_q > FOLD_MIN) begin
						nib_n[0] = fold_tens;
						nib_n[1] = fold_ones;
					end
					count_n = '0;
					step_n  = ST_VALID;
				end else if (count_q < FIELD_MAX) begin
					if (count_q < 5'(NUM_DIGITS)) nib_n[count_q[1:0]] = rx_byte[3:0];
					count_n = count_q + 5'd1;
				end
			end
			ST_VALID, ST_STAR: begin
				if (step_q == ST_VALID) begin
					fix_n  = (rx_byte == CHAR_A);
					step_n = ST_STAR;
				end
				// An empty validity field lets the star land in the same step.
				if (rx_byte == CHAR_STAR) begin
					capt_n = xor_q;
					step_n = ST_SUM_HI;
				end
			end
			ST_SUM_HI: begin
				sum_hi_n = hex_nibble(rx_byte);
				step_n   = ST_SUM_LO;
			end
			ST_SUM_LO: begin
				hit    = (capt_q == {sum_hi_q, hex_nibble(rx_byte)});
				for (int i = 0; i < NUM_DIGITS; i++) nib_n[i] = '0;
				step_n = ST_DOLLAR;
			end
			default: begin
				step_n = (rx_byte == CHAR_DOLLAR) ? ST_G : ST_DOLLAR;
				xor_n  = '0;
			end
		endcase
	end

	assign result.hit         = hit;
	assign result.fix_valid   = fix_q;
	assign result.hour_tens   = nib_q[0];
	assign result.hour_ones   = nib_q[1];
	assign result.minute_tens = nib_q[2];
	assign result.minute_ones = nib_q[3];

endmodule

// ----- src/nmea_rmc_time_to_segments.sv -----
// Top level of the NMEA RMC time-to-segment block.
// Depends on nrmc_pkg, the three channel interfaces and nrmc_parser.
//
// This block watches a stream of received NMEA 0183 characters, one item per
// byte, for "$GPRMC," sentences. It keeps the first four characters of the
// time field as hour and minute digits and, when the field is longer than
// seven characters, folds the UTC hour to 12-hour form and subtracts the zone
// offset register (reset value 4). It notes whether the fix is valid ('A'),
// checks the XOR checksum against the two uppercase hex digits after '*', and
// on a match emits one item of four seven-segment bytes, with the colon bit
// set on the hour ones digit when the fix is valid. A sentence whose checksum
// fails produces nothing. Each byte goes from acceptance into the input
// register and then through the parser into the result register. A new byte
// is accepted every cycle; the only thing that holds input back is a finished
// result that the sink has not yet taken, because the parser state advances
// only when the result register is free.
// The zone offset is written through the configuration channel, which is
// always ready, and should only be written while no bytes are in flight.
module nmea_rmc_time_to_segments
	import nrmc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	nrmc_rx_if.sink     rx,
	nrmc_seg_if.source  seg,
	nrmc_cfg_if.sink    cfg
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [3:0] zone_q;
	logic       out_valid_q;
	logic [7:0] hour_tens_q;
	logic [7:0] hour_ones_q;
	logic [7:0] minute_tens_q;
	logic [7:0] minute_ones_q;
	logic       out_free;
	logic       advance;
	nrmc_time_t parsed;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || seg.ready;
	// The staged byte runs through the parser once the result side is free.
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_RESET;
		end else if (cfg.valid) begin
			zone_q <= cfg.zone_offset_hours;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	nrmc_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.rx_byte (byte_s1),
		.zone    (zone_q),
		.result  (parsed)
	);

	// Result register: a valid flag plus the encoded segment bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && parsed.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && parsed.hit) begin
			hour_tens_q   <= seg_digit(parsed.hour_tens);
			hour_ones_q   <= seg_digit(parsed.hour_ones) |
				(parsed.fix_valid ? COLON_BIT : 8'h00);
			minute_tens_q <= seg_digit(parsed.minute_tens);
			minute_ones_q <= seg_digit(parsed.minute_ones);
		end
	end

	assign seg.valid           = out_valid_q;
	assign seg.seg_hour_tens   = hour_tens_q;
	assign seg.seg_hour_ones   = hour_ones_q;
	assign seg.seg_minute_tens = minute_tens_q;
	assign seg.seg_minute_ones = minute_ones_q;

endmodule

// ----- src/nrmc_checker.sv -----
// Port-level checks for the NMEA RMC time-to-segment block, bound to the top.
// Depends on the top level's ports only.
module nrmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       seg_valid,
	input logic       seg_ready,
	input logic [7:0] seg_hour_tens,
	input logic [7:0] seg_hour_ones,
	input logic [7:0] seg_minute_tens,
	input logic [7:0] seg_minute_ones
);

	// A stalled result keeps its bytes.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && !seg_ready |=> seg_valid && $stable(seg_hour_tens) &&
		$stable(seg_hour_ones) && $stable(seg_minute_tens) && $stable(seg_minute_ones))
		else $error("result changed while stalled");

	// Input only backs up behind a result the sink is refusing.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> seg_valid && !seg_ready)
		else $error("input stalled without output back-pressure");

	// A fresh result comes from an accepted byte that went into the input register
	// and then through the parser into the result register.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(seg_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result appeared without a byte behind it");

	// Only the hour ones digit carries the colon.
	a_colon: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> !seg_hour_tens[7] && !seg_minute_tens[7] && !seg_minute_ones[7])
		else $error("colon bit on a digit other than hour ones");

endmodule

bind nmea_rmc_time_to_segments nrmc_checker u_nrmc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rx_valid        (rx.valid),
	.rx_ready        (rx.ready),
	.seg_valid       (seg.valid),
	.seg_ready       (seg.ready),
	.seg_hour_tens   (seg.seg_hour_tens),
	.seg_hour_ones   (seg.seg_hour_ones),
	.seg_minute_tens (seg.seg_minute_tens),
	.seg_minute_ones (seg.seg_minute_ones)
);
